// ----- design/blob_autotile_classifier_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the blob autotile classifier
// Immediate-consequence and next-cycle checks, sampled on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef BLOB_AUTOTILE_CLASSIFIER_CORE_ASSERT_SVH
`define BLOB_AUTOTILE_CLASSIFIER_CORE_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define BAT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define BAT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/bat_pkg.sv -----
// ----------------------------------------------------------------------------
// bat_pkg
// Shared types, sheet table and mask helpers of the blob autotile classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package bat_pkg;

    // one column slot of the two line stores
    typedef struct packed {
        logic older;
        logic newer;
    } bat_taps_t;

    localparam int SHEET_SLOTS = 48;
    localparam logic [3:0] SHEET_LAST_ROW = 4'd11;

    // blank slot is 9'h100, which no 8-bit mask matches
    localparam logic [8:0] SHEET_MASKS [SHEET_SLOTS] = '{
        9'd16,  9'd17,  9'd1,   9'd0,
        9'd20,  9'd21,  9'd5,   9'd4,
        9'd84,  9'd85,  9'd69,  9'd68,
        9'd80,  9'd81,  9'd65,  9'd64,
        9'd213, 9'd29,  9'd23,  9'd117,
        9'd92,  9'd127, 9'd223, 9'd71,
        9'd116, 9'd253, 9'd247, 9'd197,
        9'd87,  9'd113, 9'd209, 9'd93,
        9'd28,  9'd31,  9'd95,  9'd7,
        9'd125, 9'd119, 9'd255, 9'd199,
        9'd124, 9'h100, 9'd221, 9'd215,
        9'd112, 9'd245, 9'd241, 9'd193
    };

    // window: bits 2..0 newest column (bottom, mid, top), 5..3 centre, 8..6 oldest
    function automatic logic [7:0] build_mask(input logic [8:0] w);
        logic [7:0] m;
        m = {w[6], w[7], w[8], w[5], w[2], w[1], w[0], w[3]};
        if (!(m[0] && m[2])) m[1] = 1'b0;
        if (!(m[2] && m[4])) m[3] = 1'b0;
        if (!(m[4] && m[6])) m[5] = 1'b0;
        if (!(m[6] && m[0])) m[7] = 1'b0;
        return m;
    endfunction

    // first matching slot, zero when none
    function automatic logic [5:0] find_slot(input logic [7:0] m);
        logic [5:0] slot;
        logic       found;
        slot  = '0;
        found = 1'b0;
        for (int i = 0; i < SHEET_SLOTS; i++) begin
            if (!found && (SHEET_MASKS[i] == {1'b0, m})) begin
                slot  = 6'(i);
                found = 1'b1;
            end
        end
        return slot;
    endfunction

endpackage

`default_nettype wire

// ----- design/bat_cell.sv -----
// ----------------------------------------------------------------------------
// bat_cell
// One column slot of both line stores; passes its bits on at each shift.
// ----------------------------------------------------------------------------
`default_nettype none

module bat_cell (
    input  wire logic               clk,
    input  wire logic               shift_en,
    input  wire bat_pkg::bat_taps_t tap_in,
    output bat_pkg::bat_taps_t      tap_out
);
    import bat_pkg::*;

    bat_taps_t taps_reg;

    // line store contents need no reset: rows 0 and 1 of a map fill them
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            taps_reg <= tap_in;
        end
    end

    assign tap_out = taps_reg;

endmodule

`default_nettype wire

// ----- design/bat_line.sv -----
// ----------------------------------------------------------------------------
// bat_line
// Chain of DEPTH cells forming the two row delay lines.
// ----------------------------------------------------------------------------
`default_nettype none

module bat_line #(
    parameter int DEPTH = 64
) (
    input  wire logic clk,
    input  wire logic shift_en,
    input  wire logic filled,
    output logic      top,
    output logic      mid
);
    import bat_pkg::*;

    bat_taps_t chain [DEPTH+1];

    // the newer line's end feeds the older line's head
    assign chain[0].newer = filled;
    assign chain[0].older = chain[DEPTH].newer;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        bat_cell u_cell (
            .clk      (clk),
            .shift_en (shift_en),
            .tap_in   (chain[i]),
            .tap_out  (chain[i+1])
        );
    end

    assign top = chain[DEPTH].older;
    assign mid = chain[DEPTH].newer;

endmodule

`default_nettype wire

// ----- design/blob_autotile_classifier_core.sv -----
// ----------------------------------------------------------------------------
// blob_autotile_classifier_core
// 47-tile blob autotile classifier over a raster-order tile map stream.
// ----------------------------------------------------------------------------
// Input words (s_*) carry one map cell each in raster order; tile_code nonzero
// means filled, s_tuser marks the first cell of a map and restarts the row and
// column counters. Output words (m_*) carry one classified interior cell: its
// position (one row up and one column left of the cell just taken), the
// diagonal-cleaned neighbour mask and the sprite-sheet column and row.
// Empty, border and first-two-rows/columns cells produce no output word.
// Throughput: one input word per cycle unless the output stalls; the line stores are a chain of
// MAP_COLUMNS cells that all shift on each accepted word.
// Pipeline: an input word's result passes the window register, then the output
// register, before it appears on m_tvalid.
// Stall: s_tready = !m_tvalid || m_tready, so the whole pipe holds while the
// output word waits; nothing is dropped.
// Reset: counters, window and valids clear; the line store contents are left
// as is, since rows 0 and 1 of every map overwrite them before use.
// ----------------------------------------------------------------------------
`default_nettype none

`include "blob_autotile_classifier_core_assert.svh"

module blob_autotile_classifier_core #(
    parameter int MAP_COLUMNS = 64,
    parameter int MAP_ROWS    = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] tile_code
    input  wire logic        s_tuser,   // [0] start_of_map
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // [5:0] cell_row, [11:6] cell_column,
                                        // [19:12] neighbour_mask,
                                        // [21:20] sheet_column, [25:22] sheet_row
);
    import bat_pkg::*;

    localparam int CW  = $clog2(MAP_COLUMNS);
    localparam int RW  = $clog2(MAP_ROWS);
    localparam int CXW = (CW > 6) ? CW : 6;
    localparam int RXW = (RW > 6) ? RW : 6;

    logic          advance;
    logic          accept;
    logic          filled;
    logic          top;
    logic          mid;
    logic          hit;
    logic [CW-1:0] col_eff;
    logic [RW-1:0] row_eff;
    logic [CXW-1:0] col_wide;
    logic [RXW-1:0] row_wide;
    logic [7:0]    mask;
    logic [5:0]    slot;

    logic [8:0]    window_reg;
    logic [8:0]    window_next;
    logic [CW-1:0] col_reg;
    logic [CW-1:0] col_next;
    logic [RW-1:0] row_reg;
    logic [RW-1:0] row_next;
    logic          s1_valid_reg;
    logic [5:0]    s1_row_reg;
    logic [5:0]    s1_col_reg;
    logic          m_valid_reg;
    logic [31:0]   m_tdata_reg;
    logic [31:0]   m_tdata_next;

    assign advance  = !m_valid_reg || m_tready;
    assign s_tready = advance;
    assign accept   = s_tvalid && advance;
    assign filled   = |s_tdata;

    bat_line #(
        .DEPTH (MAP_COLUMNS)
    ) u_line (
        .clk      (clk),
        .shift_en (accept),
        .filled   (filled),
        .top      (top),
        .mid      (mid)
    );

    always_comb
    begin
        col_eff     = s_tuser ? '0 : col_reg;
        row_eff     = s_tuser ? '0 : row_reg;
        window_next = {window_reg[5:0], filled, mid, top};
        hit         = (row_eff >= RW'(2)) && (col_eff >= CW'(2)) && window_next[4];
        col_wide    = CXW'(col_eff) - CXW'(1);
        row_wide    = RXW'(row_eff) - RXW'(1);
        if (col_eff == CW'(MAP_COLUMNS - 1))
        begin
            col_next = '0;
            row_next = (row_eff == RW'(MAP_ROWS - 1)) ? '0 : row_eff + RW'(1);
        end
        else
        begin
            col_next = col_eff + CW'(1);
            row_next = row_eff;
        end
    end

    // classify from the window register, which holds the item in stage one
    always_comb
    begin
        mask         = build_mask(window_reg);
        slot         = find_slot(mask);
        m_tdata_next = {6'd0, slot[5:2], slot[1:0], mask, s1_col_reg, s1_row_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg   <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                window_reg <= window_next;
                col_reg    <= col_next;
                row_reg    <= row_next;
            end
            if (advance)
            begin
                s1_valid_reg <= accept && hit;
                m_valid_reg  <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_row_reg  <= row_wide[5:0];
            s1_col_reg  <= col_wide[5:0];
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_tdata_reg;

    `BAT_ASSERT_NOW(a_centre_filled, s1_valid_reg, window_reg[4],
        "stage one holds a result with an empty centre cell")
    `BAT_ASSERT_NEXT(a_start_restarts, accept && s_tuser,
        (col_reg == CW'(1)) && (row_reg == '0),
        "start of map did not restart the position counters")
    `BAT_ASSERT_NOW(a_diag_cleaned, m_valid_reg,
        (!m_tdata_reg[13] || (m_tdata_reg[12] && m_tdata_reg[14])) &&
        (!m_tdata_reg[15] || (m_tdata_reg[14] && m_tdata_reg[16])) &&
        (!m_tdata_reg[17] || (m_tdata_reg[16] && m_tdata_reg[18])) &&
        (!m_tdata_reg[19] || (m_tdata_reg[18] && m_tdata_reg[12])),
        "diagonal bit set without both adjacent edge bits")
    `BAT_ASSERT_NOW(a_sheet_row_range, m_valid_reg,
        m_tdata_reg[25:22] <= SHEET_LAST_ROW,
        "sheet row beyond the last sheet row")

endmodule

`default_nettype wire
